// ----- hw/rtl/skl_pkg.sv -----
package skl_pkg;

   localparam int KEY_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_DUMP   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CMP,
      ST_REM_READ,
      ST_REM_CMP,
      ST_SHF_READ,
      ST_SHF_WRITE,
      ST_DUMP
   } state_type;

endpackage

// ----- hw/rtl/sorted_key_list.sv -----
// clear, full insert and empty cases strobe their result in the cycle after the accept edge
// insert: reads keys from the top down, moves each one not smaller up a slot, then writes the key
// remove: reads and compares keys from slot zero, then moves each later key down; a miss ends at the last key
// dump: keys are read and strobed one per cycle; next accept in last strobe cycle
// the key table has one read and one write port with a registered read; one shared compare unit
// synchronous reset empties the table and clears control; the receiver cannot stall
module sorted_key_list #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_key_out,
   output logic               rsp_last
);
   import skl_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic signed [KEY_W-1:0] key_ff, key_in;

   // key table, single write and single read port
   logic signed [KEY_W-1:0] keys_ff [CAPACITY];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic                    rd_en, wr_en;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic signed [KEY_W-1:0] wr_data;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_mem_sel_ff, rsp_mem_sel_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   op_type           req_op;
   logic [CNT_W-1:0] idx_dec, idx_inc;
   logic             stored_less, stored_equal, idx_at_end;

   assign accept  = start && (state_ff == ST_IDLE);
   assign req_op  = op_type'(req_operation);
   assign idx_dec = idx_ff - ONE;
   assign idx_inc = idx_ff + ONE;

   // the one shared compare unit, stored key against the request key
   assign stored_less  = rd_data_ff < key_ff;
   assign stored_equal = rd_data_ff == key_ff;
   assign idx_at_end   = idx_inc == count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_INSERT: if (count_ff != CAP_CNT) state_in = ST_INS_READ;
                  OP_REMOVE: if (count_ff != '0) state_in = ST_REM_READ;
                  OP_DUMP:   if (count_ff != '0) state_in = ST_DUMP;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_READ:  state_in = (idx_ff == '0) ? ST_IDLE : ST_INS_CMP;
         ST_INS_CMP:   state_in = stored_less ? ST_IDLE : ST_INS_READ;
         ST_REM_READ:  state_in = ST_REM_CMP;
         ST_REM_CMP: begin
            if (stored_equal) state_in = ST_SHF_READ;
            else if (idx_at_end) state_in = ST_IDLE;
            else state_in = ST_REM_READ;
         end
         ST_SHF_READ:  state_in = idx_at_end ? ST_IDLE : ST_SHF_WRITE;
         ST_SHF_WRITE: state_in = ST_SHF_READ;
         ST_DUMP:      state_in = idx_at_end ? ST_IDLE : ST_DUMP;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      key_in         = key_ff;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IDX_W-1:0];
      wr_data        = key_ff;
      rsp_valid_in   = 1'b0;
      rsp_mem_sel_in = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_key_in     = '0;
      rsp_last_in    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in = req_key;
               idx_in = '0;
               case (req_op)
                  OP_INSERT: begin
                     idx_in = count_ff;
                     if (count_ff == CAP_CNT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_REMOVE, OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_INS_READ: begin
            if (idx_ff == '0) begin
               wr_en        = 1'b1;
               count_in     = count_ff + ONE;
               rsp_valid_in = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_dec[IDX_W-1:0];
            end
         end
         ST_INS_CMP: begin
            // keys not smaller than the new one move up a slot
            wr_en = 1'b1;
            if (stored_less) begin
               count_in     = count_ff + ONE;
               rsp_valid_in = 1'b1;
            end else begin
               wr_data = rd_data_ff;
               idx_in  = idx_dec;
            end
         end
         ST_REM_READ: rd_en = 1'b1;
         ST_REM_CMP: begin
            if (!stored_equal) begin
               if (idx_at_end) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_NOT_FOUND;
               end else begin
                  idx_in = idx_inc;
               end
            end
         end
         ST_SHF_READ: begin
            if (idx_at_end) begin
               count_in     = count_ff - ONE;
               rsp_valid_in = 1'b1;
               rsp_key_in   = key_ff;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_inc[IDX_W-1:0];
            end
         end
         ST_SHF_WRITE: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_inc;
         end
         ST_DUMP: begin
            // read data lands next cycle, right when the strobe is up
            rd_en          = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_mem_sel_in = 1'b1;
            rsp_last_in    = idx_at_end;
            idx_in         = idx_inc;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) keys_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= keys_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      key_ff         <= key_in;
      rsp_mem_sel_ff <= rsp_mem_sel_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_key_out = rsp_mem_sel_ff ? rd_data_ff : rsp_key_ff;
   assign rsp_last    = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_dump_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a dump stream");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transaction neither running nor answered");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy || state_ff == ST_DUMP)
      else $error("result strobe during a table update");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> count_ff == CAP_CNT)
      else $error("full reported on a table with room");

endmodule

// ----- dv/tb_sorted_key_list.sv -----
module tb_sorted_key_list;
   import skl_pkg::*;

   localparam int CAPACITY = 16;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] key_out;
      logic                    last;
   } answer_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [1:0]              req_operation;
   logic signed [KEY_W-1:0] req_key;
   logic                    rsp_valid;
   logic [1:0]              rsp_status;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic                    rsp_last;

   // shadow copy of the table contents, kept in ascending order
   logic signed [KEY_W-1:0] shadow_keys[$];
   answer_type              due_answers[$];
   int                      mismatch_count = 0;
   int                      burst_left = 0;

   sorted_key_list #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operation(req_operation),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_key_out  (rsp_key_out),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #300000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void queue_answer(status_type status, logic signed [KEY_W-1:0] key_out,
                                        logic last);
      answer_type a;
      a.status  = status;
      a.key_out = key_out;
      a.last    = last;
      due_answers.push_back(a);
   endfunction

   function automatic void predict_list_answers(op_type op, logic signed [KEY_W-1:0] key);
      int pos;
      pos = 0;
      case (op)
         OP_INSERT: begin
            if (shadow_keys.size() >= CAPACITY) begin
               queue_answer(STATUS_FULL, '0, 1'b1);
            end else begin
               // new key goes ahead of the first stored key that is not smaller
               while (pos < shadow_keys.size() && shadow_keys[pos] < key) pos++;
               shadow_keys.insert(pos, key);
               queue_answer(STATUS_OK, '0, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (shadow_keys.size() == 0) begin
               queue_answer(STATUS_EMPTY, '0, 1'b1);
            end else begin
               while (pos < shadow_keys.size() && shadow_keys[pos] != key) pos++;
               if (pos >= shadow_keys.size()) begin
                  queue_answer(STATUS_NOT_FOUND, '0, 1'b1);
               end else begin
                  shadow_keys.delete(pos);
                  queue_answer(STATUS_OK, key, 1'b1);
               end
            end
         end
         OP_DUMP: begin
            if (shadow_keys.size() == 0) begin
               queue_answer(STATUS_EMPTY, '0, 1'b1);
            end else begin
               foreach (shadow_keys[i])
                  queue_answer(STATUS_OK, shadow_keys[i], i == shadow_keys.size() - 1);
            end
         end
         default: begin
            shadow_keys.delete();
            queue_answer(STATUS_OK, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void note_mismatch(string what, answer_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected status %0d key %0d last %0b, got status %0d key %0d last %0b",
                  $time, what, want.status, want.key_out, want.last,
                  rsp_status, rsp_key_out, rsp_last);
   endfunction

   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid) begin
         if (due_answers.size() == 0) begin
            want = '0;
            note_mismatch("unexpected result", want);
         end else begin
            want = due_answers.pop_front();
            if (rsp_status !== want.status || rsp_key_out !== want.key_out ||
                rsp_last !== want.last)
               note_mismatch("result mismatch", want);
         end
      end
   end

   // sender works in bursts, dropping start between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
      end
   endtask

   task automatic send_item(op_type op, logic signed [KEY_W-1:0] key);
      @(negedge clock);
      start         <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_list_answers(op, key);
      pace_sender();
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      logic signed [KEY_W-1:0] k;
      case ($urandom_range(0, 3))
         0: k = $urandom;
         1: k = $signed($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 4))
               0: k = KEY_MIN;
               1: k = KEY_MAX;
               2: k = KEY_MIN + 1;
               3: k = KEY_MAX - 1;
               default: k = '0;
            endcase
         end
         default: begin
            if (shadow_keys.size() != 0)
               k = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
            else
               k = $urandom;
         end
      endcase
      return k;
   endfunction

   task automatic test_empty_table();
      send_item(OP_REMOVE, 32'sd5);
      send_item(OP_DUMP, $urandom);
      send_item(OP_CLEAR, $urandom);
   endtask

   task automatic test_key_extremes();
      send_item(OP_INSERT, KEY_MAX);
      send_item(OP_INSERT, KEY_MIN);
      send_item(OP_INSERT, '0);
      send_item(OP_INSERT, -32'sd1);
      send_item(OP_INSERT, KEY_MIN);
      send_item(OP_INSERT, 32'sd1);
      send_item(OP_DUMP, '0);
      send_item(OP_REMOVE, 32'sd7);
      send_item(OP_REMOVE, KEY_MIN);
      send_item(OP_REMOVE, KEY_MAX);
      send_item(OP_REMOVE, -32'sd1);
      send_item(OP_DUMP, '1);
      send_item(OP_CLEAR, '0);
   endtask

   task automatic test_table_full();
      repeat (CAPACITY + 2) send_item(OP_INSERT, pick_key());
      send_item(OP_DUMP, pick_key());
      repeat (3) send_item(OP_REMOVE, pick_key());
      repeat (4) send_item(OP_INSERT, pick_key());
      send_item(OP_DUMP, pick_key());
   endtask

   task automatic test_random_traffic(int item_total);
      int     sent;
      int     phase_left;
      int     phase_kind;
      int     roll;
      op_type op;
      sent       = 0;
      phase_left = 0;
      phase_kind = 0;
      while (sent < item_total) begin
         if (phase_left == 0) begin
            phase_kind = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 40);
         end
         roll = $urandom_range(0, 99);
         // grow, shrink and mixed phases push the table toward full and empty
         case (phase_kind)
            0:       op = roll < 70 ? OP_INSERT : roll < 85 ? OP_REMOVE
                        : roll < 97 ? OP_DUMP : OP_CLEAR;
            1:       op = roll < 20 ? OP_INSERT : roll < 85 ? OP_REMOVE
                        : roll < 97 ? OP_DUMP : OP_CLEAR;
            default: op = roll < 40 ? OP_INSERT : roll < 75 ? OP_REMOVE
                        : roll < 95 ? OP_DUMP : OP_CLEAR;
         endcase
         send_item(op, pick_key());
         sent++;
         phase_left--;
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_INSERT;
      req_key       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_key_extremes();
      test_table_full();
      test_random_traffic(170);

      @(negedge clock);
      start <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
      // a remove walks the table at most once, so leave room for a stray result
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sorted_key_list.f -----
hw/rtl/skl_pkg.sv
hw/rtl/sorted_key_list.sv
dv/tb_sorted_key_list.sv
